### rtl/htw_pkg.sv
// htw_pkg: shared widths, slot map, codes and types of the hierarchical timer wheel
// no dependencies; imported by every module of the block
package htw_pkg;

    localparam int TASK_N      = 64;
    localparam int TASK_W      = $clog2(TASK_N);
    localparam int LINK_W      = TASK_W + 1;
    localparam int TICK_W      = 20;
    localparam int CNT_W       = $clog2(TASK_N + 1);

    localparam int FINE_BITS   = 8;
    localparam int MID_BITS    = 6;
    localparam int COARSE_BITS = 6;
    localparam int FINE_SLOTS   = 1 << FINE_BITS;
    localparam int MID_SLOTS    = 1 << MID_BITS;
    localparam int COARSE_SLOTS = 1 << COARSE_BITS;
    localparam int NUM_SLOTS    = FINE_SLOTS + MID_SLOTS + COARSE_SLOTS + 1;
    localparam int SLOT_W       = $clog2(NUM_SLOTS + 1);

    localparam logic [LINK_W-1:0] NIL_LINK      = LINK_W'(TASK_N);
    localparam logic [SLOT_W-1:0] MID_BASE_S    = SLOT_W'(FINE_SLOTS);
    localparam logic [SLOT_W-1:0] COARSE_BASE_S = SLOT_W'(FINE_SLOTS + MID_SLOTS);
    localparam logic [SLOT_W-1:0] FOREVER_S     = SLOT_W'(FINE_SLOTS + MID_SLOTS + COARSE_SLOTS);
    localparam logic [SLOT_W-1:0] BAD_S         = SLOT_W'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT_S   = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_ADVANCE = 2'd2;

    typedef enum logic [2:0] {
        KIND_EXPIRED     = 3'd0,
        KIND_ADDED       = 3'd1,
        KIND_REMOVED     = 3'd2,
        KIND_RANGE       = 3'd3,
        KIND_NOT_PAUSED  = 3'd4,
        KIND_ALREADY     = 3'd5,
        KIND_DONE        = 3'd6
    } result_kind_t;

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
    } slot_ent_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLR,
        OP_ADD_SETUP,
        OP_SLOT_RD,
        OP_APP_WR,
        OP_APP_LINK,
        OP_ADD_DONE,
        OP_PUSH,
        OP_UL_RD,
        OP_UL_A,
        OP_UL_B,
        OP_REM_DONE,
        OP_SEL_COARSE,
        OP_SEL_MID,
        OP_SEL_FINE,
        OP_TAKE,
        OP_RF_RD,
        OP_RF_SET,
        OP_EX,
        OP_EX_NEXT,
        OP_TICK_END,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t       op;
        result_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic act_add;
        logic act_remove;
        logic act_advance;
        logic tid_paused;
        logic add_bad;
        logic tail_nil;
        logic walk_nil;
        logic more_ticks;
        logic fine_zero;
        logic mid_zero;
        logic coarse_ok;
        logic out_free;
        logic pend_valid;
        logic clr_last;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_APP_RD,
        ST_APP_WR,
        ST_APP_LINK,
        ST_ADD_DONE,
        ST_UL_A,
        ST_UL_B,
        ST_REM_DONE,
        ST_TICK,
        ST_RF_RD,
        ST_RF_TAKE,
        ST_RF_CHK,
        ST_RF_SET,
        ST_EX_RD,
        ST_EX_TAKE,
        ST_EX_CHK,
        ST_EX_NEXT,
        ST_TICK_CHK,
        ST_FINISH
    } ctrl_state_t;

    // slot list for a wake tick relative to the current base
    function automatic logic [SLOT_W-1:0] slot_for(input logic [TICK_W-1:0] wake,
                                                   input logic [TICK_W-1:0] base);
        logic [TICK_W-1:0] wf;
        logic [TICK_W-1:0] bf;
        logic [TICK_W-1:0] wm;
        logic [TICK_W-1:0] bm;
        wf = wake >> FINE_BITS;
        bf = base >> FINE_BITS;
        wm = wf >> MID_BITS;
        bm = bf >> MID_BITS;
        if (wake == '0)
            slot_for = FOREVER_S;
        else if (wf == bf)
            slot_for = SLOT_W'(wake[FINE_BITS-1:0]);
        else if (wm == bm)
            slot_for = MID_BASE_S + SLOT_W'(wf[MID_BITS-1:0]);
        else if (wm >= TICK_W'(COARSE_SLOTS))
            slot_for = BAD_S;
        else
            slot_for = COARSE_BASE_S + SLOT_W'(wm[COARSE_BITS-1:0]);
    endfunction

endpackage

### rtl/hierarchical_timer_wheel.sv
// hierarchical_timer_wheel: three-level timing wheel for task identifiers, top level
// depends on htw_pkg, htw_ctrl and htw_datapath
//
// After reset the block sweeps its 385-entry slot list memory and takes no transfer
// until done. Then one command is worked at a time. An add writes the task links and
// slot entry and links the old tail; a remove patches its neighbours and the slot entry;
// a refused add or remove only sends its result. An advance steps tick by tick, expiring
// the tasks of each fine slot; at a fine-slot wrap it first re-files the coarse (at a
// middle wrap) and middle slot lists. Results leave through a one-entry output register,
// and a stalled receiver holds the sequencer.
module hierarchical_timer_wheel
    import htw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // task_id, wake_time, now_tick, zero pad
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_task, paused_count, zero pad
    output logic [2:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [TASK_W-1:0] out_task;
    logic [CNT_W-1:0]  out_count;

    htw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    htw_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_action (s_axis_tuser),
        .in_task   (s_axis_tdata[5:0]),
        .in_wake   (s_axis_tdata[25:6]),
        .in_now    (s_axis_tdata[45:26]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_task  (out_task),
        .out_kind  (m_axis_tuser),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_count, out_task};

endmodule

### rtl/htw_datapath.sv
// htw_datapath: task and slot list memories, wheel base, counters and result register
// depends on htw_pkg; driven by htw_ctrl at most one operation per cycle
module htw_datapath
    import htw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [1:0]          in_action,
    input  logic [TASK_W-1:0]   in_task,
    input  logic [TICK_W-1:0]   in_wake,
    input  logic [TICK_W-1:0]   in_now,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TASK_W-1:0]   out_task,
    output logic [2:0]          out_kind,
    output logic [CNT_W-1:0]    out_count,
    output logic                out_last
);

    logic [1:0]          act_reg, act_next;
    logic [TASK_W-1:0]   tid_reg, tid_next;
    logic [TICK_W-1:0]   wake_reg, wake_next;
    logic [TICK_W-1:0]   now_reg, now_next;
    logic [TICK_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [TASK_N-1:0]   paused_reg, paused_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TASK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   walk_reg, walk_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [TASK_W-1:0]   pend_task_reg, pend_task_next;
    logic [CNT_W-1:0]    pend_cnt_reg, pend_cnt_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [TASK_W-1:0]   out_task_reg, out_task_next;
    logic [2:0]          out_kind_reg, out_kind_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic                out_last_reg, out_last_next;

    logic [LINK_W-1:0]   next_mem [TASK_N];
    logic [LINK_W-1:0]   prev_mem [TASK_N];
    logic [TICK_W-1:0]   wake_mem [TASK_N];
    logic [SLOT_W-1:0]   tag_mem  [TASK_N];
    slot_ent_t           slot_mem [NUM_SLOTS];

    logic [LINK_W-1:0]   nx_rd, pv_rd;
    logic [TICK_W-1:0]   wk_rd;
    logic [SLOT_W-1:0]   tg_rd;
    slot_ent_t           sm_rd;

    logic                nx_we, pv_we, wk_we, tg_we, sm_we;
    logic [TASK_W-1:0]   nx_waddr, pv_waddr, wk_waddr, tg_waddr;
    logic [SLOT_W-1:0]   sm_waddr;
    logic [LINK_W-1:0]   nx_wdata, pv_wdata;
    logic [TICK_W-1:0]   wk_wdata;
    logic [SLOT_W-1:0]   tg_wdata;
    slot_ent_t           sm_wdata;
    logic                nx_re, pv_re, wk_re, tg_re, sm_re;
    logic [TASK_W-1:0]   nx_raddr, pv_raddr, wk_raddr, tg_raddr;
    logic [SLOT_W-1:0]   sm_raddr;

    logic                out_free;
    logic [TICK_W-1:0]   wake_eff;
    logic [SLOT_W-1:0]   add_slot;
    logic [SLOT_W-1:0]   refile_slot;
    logic [TICK_W-1:0]   coarse_idx;
    logic [CNT_W-1:0]    held_dec;
    logic                push;
    logic [TASK_W-1:0]   push_task;
    result_kind_t        push_kind;
    logic [CNT_W-1:0]    push_cnt;
    logic                push_last;
    slot_ent_t           empty_ent;

    assign out_free   = !out_valid_reg || out_ready;
    assign wake_eff   = (wake_reg != '0 && wake_reg < base_reg) ? base_reg : wake_reg;
    assign add_slot   = slot_for(wake_eff, base_reg);
    assign refile_slot = slot_for(wk_rd, base_reg);
    assign coarse_idx = base_reg >> (FINE_BITS + MID_BITS);
    assign held_dec   = (held_reg == '0) ? held_reg : held_reg - CNT_W'(1);
    assign empty_ent  = '{head: NIL_LINK, tail: NIL_LINK};

    always_comb
    begin
        act_next        = act_reg;
        tid_next        = tid_reg;
        wake_next       = wake_reg;
        now_next        = now_reg;
        base_next       = base_reg;
        held_next       = held_reg;
        paused_next     = paused_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        pend_valid_next = pend_valid_reg;
        pend_task_next  = pend_task_reg;
        pend_cnt_next   = pend_cnt_reg;
        clr_next        = clr_reg;
        nx_we = 1'b0; pv_we = 1'b0; wk_we = 1'b0; tg_we = 1'b0; sm_we = 1'b0;
        nx_waddr = '0; pv_waddr = '0; wk_waddr = '0; tg_waddr = '0; sm_waddr = '0;
        nx_wdata = '0; pv_wdata = '0; wk_wdata = '0; tg_wdata = '0; sm_wdata = empty_ent;
        nx_re = 1'b0; pv_re = 1'b0; wk_re = 1'b0; tg_re = 1'b0; sm_re = 1'b0;
        nx_raddr = '0; pv_raddr = '0; wk_raddr = '0; tg_raddr = '0; sm_raddr = '0;
        push      = 1'b0;
        push_task = tid_reg;
        push_kind = cmd.kind;
        push_cnt  = held_reg;
        push_last = 1'b1;
        case (cmd.op)
            OP_LATCH:
            begin
                act_next  = in_action;
                tid_next  = in_task;
                wake_next = in_wake;
                now_next  = in_now;
            end
            OP_CLR:
            begin
                sm_we    = 1'b1;
                sm_waddr = clr_reg;
                clr_next = clr_reg + SLOT_W'(1);
            end
            OP_ADD_SETUP:
            begin
                wk_we     = 1'b1;
                wk_waddr  = tid_reg;
                wk_wdata  = wake_eff;
                slot_next = add_slot;
                cur_next  = tid_reg;
            end
            OP_SLOT_RD:
            begin
                sm_re    = 1'b1;
                sm_raddr = slot_reg;
            end
            OP_APP_WR:
            begin
                nx_we    = 1'b1;
                nx_waddr = cur_reg;
                nx_wdata = NIL_LINK;
                pv_we    = 1'b1;
                pv_waddr = cur_reg;
                pv_wdata = sm_rd.tail;
                tg_we    = 1'b1;
                tg_waddr = cur_reg;
                tg_wdata = slot_reg;
                sm_we    = 1'b1;
                sm_waddr = slot_reg;
                sm_wdata.tail = LINK_W'(cur_reg);
                sm_wdata.head = (sm_rd.tail == NIL_LINK) ? LINK_W'(cur_reg) : sm_rd.head;
            end
            OP_APP_LINK:
            begin
                nx_we    = 1'b1;
                nx_waddr = sm_rd.tail[TASK_W-1:0];
                nx_wdata = LINK_W'(cur_reg);
            end
            OP_ADD_DONE:
            begin
                paused_next[tid_reg] = 1'b1;
                held_next = held_reg + CNT_W'(1);
                push      = 1'b1;
                push_kind = KIND_ADDED;
                push_cnt  = held_reg + CNT_W'(1);
            end
            OP_PUSH:
            begin
                push = 1'b1;
            end
            OP_UL_RD:
            begin
                nx_re = 1'b1; pv_re = 1'b1; tg_re = 1'b1;
                nx_raddr = tid_reg; pv_raddr = tid_reg; tg_raddr = tid_reg;
            end
            OP_UL_A:
            begin
                sm_re     = 1'b1;
                sm_raddr  = tg_rd;
                slot_next = tg_rd;
                if (pv_rd != NIL_LINK)
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rd[TASK_W-1:0];
                    nx_wdata = nx_rd;
                end
            end
            OP_UL_B:
            begin
                if (nx_rd != NIL_LINK)
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rd[TASK_W-1:0];
                    pv_wdata = pv_rd;
                end
                sm_we    = 1'b1;
                sm_waddr = slot_reg;
                sm_wdata.head = (pv_rd == NIL_LINK) ? nx_rd : sm_rd.head;
                sm_wdata.tail = (nx_rd == NIL_LINK) ? pv_rd : sm_rd.tail;
            end
            OP_REM_DONE:
            begin
                paused_next[tid_reg] = 1'b0;
                held_next = held_dec;
                push      = 1'b1;
                push_kind = KIND_REMOVED;
                push_cnt  = held_dec;
            end
            OP_SEL_COARSE:
            begin
                slot_next = COARSE_BASE_S + SLOT_W'(coarse_idx[COARSE_BITS-1:0]);
            end
            OP_SEL_MID:
            begin
                slot_next = MID_BASE_S + SLOT_W'(base_reg[FINE_BITS +: MID_BITS]);
            end
            OP_SEL_FINE:
            begin
                slot_next = SLOT_W'(base_reg[FINE_BITS-1:0]);
            end
            OP_TAKE:
            begin
                walk_next = sm_rd.head;
                sm_we     = 1'b1;
                sm_waddr  = slot_reg;
            end
            OP_RF_RD:
            begin
                nx_re    = 1'b1;
                wk_re    = 1'b1;
                nx_raddr = walk_reg[TASK_W-1:0];
                wk_raddr = walk_reg[TASK_W-1:0];
                cur_next = walk_reg[TASK_W-1:0];
            end
            OP_RF_SET:
            begin
                walk_next = nx_rd;
                slot_next = (refile_slot >= BAD_S) ? FOREVER_S : refile_slot;
            end
            OP_EX:
            begin
                nx_re    = 1'b1;
                nx_raddr = walk_reg[TASK_W-1:0];
                paused_next[walk_reg[TASK_W-1:0]] = 1'b0;
                held_next = held_dec;
                if (pend_valid_reg)
                begin
                    push      = 1'b1;
                    push_task = pend_task_reg;
                    push_kind = KIND_EXPIRED;
                    push_cnt  = pend_cnt_reg;
                    push_last = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_task_next  = walk_reg[TASK_W-1:0];
                pend_cnt_next   = held_dec;
            end
            OP_EX_NEXT:
            begin
                walk_next = nx_rd;
            end
            OP_TICK_END:
            begin
                base_next = base_reg + TICK_W'(1);
            end
            OP_FINISH:
            begin
                push = 1'b1;
                if (pend_valid_reg)
                begin
                    push_task = pend_task_reg;
                    push_kind = KIND_EXPIRED;
                    push_cnt  = pend_cnt_reg;
                end
                else
                begin
                    push_task = '0;
                    push_kind = KIND_DONE;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_task_next  = out_task_reg;
        out_kind_next  = out_kind_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_task_next  = push_task;
            out_kind_next  = push_kind;
            out_cnt_next   = push_cnt;
            out_last_next  = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            held_reg       <= '0;
            paused_reg     <= '0;
            pend_valid_reg <= 1'b0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            base_reg       <= base_next;
            held_reg       <= held_next;
            paused_reg     <= paused_next;
            pend_valid_reg <= pend_valid_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        tid_reg       <= tid_next;
        wake_reg      <= wake_next;
        now_reg       <= now_next;
        slot_reg      <= slot_next;
        cur_reg       <= cur_next;
        walk_reg      <= walk_next;
        pend_task_reg <= pend_task_next;
        pend_cnt_reg  <= pend_cnt_next;
        out_task_reg  <= out_task_next;
        out_kind_reg  <= out_kind_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    // list memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_waddr] <= nx_wdata;
        if (nx_re)
            nx_rd <= next_mem[nx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            prev_mem[pv_waddr] <= pv_wdata;
        if (pv_re)
            pv_rd <= prev_mem[pv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
            wake_mem[wk_waddr] <= wk_wdata;
        if (wk_re)
            wk_rd <= wake_mem[wk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tg_we)
            tag_mem[tg_waddr] <= tg_wdata;
        if (tg_re)
            tg_rd <= tag_mem[tg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
            slot_mem[sm_waddr] <= sm_wdata;
        if (sm_re)
            sm_rd <= slot_mem[sm_raddr];
    end

    always_comb
    begin
        status.act_add     = (act_reg == ACT_ADD);
        status.act_remove  = (act_reg == ACT_REMOVE);
        status.act_advance = (act_reg == ACT_ADVANCE);
        status.tid_paused  = paused_reg[tid_reg];
        status.add_bad     = (add_slot >= BAD_S);
        status.tail_nil    = (sm_rd.tail == NIL_LINK);
        status.walk_nil    = (walk_reg == NIL_LINK);
        status.more_ticks  = (base_reg < now_reg);
        status.fine_zero   = (base_reg[FINE_BITS-1:0] == '0);
        status.mid_zero    = (base_reg[FINE_BITS +: MID_BITS] == '0);
        status.coarse_ok   = (coarse_idx < TICK_W'(COARSE_SLOTS));
        status.out_free    = out_free;
        status.pend_valid  = pend_valid_reg;
        status.clr_last    = (clr_reg == LAST_SLOT_S);
    end

    assign out_valid = out_valid_reg;
    assign out_task  = out_task_reg;
    assign out_kind  = out_kind_reg;
    assign out_count = out_cnt_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/htw_ctrl.sv
// htw_ctrl: sequencer for add, remove, slot re-filing and expiry walks
// depends on htw_pkg; issues at most one datapath operation per cycle from its status
module htw_ctrl
    import htw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        app_add_reg, app_add_next;
    logic        rf_coarse_reg, rf_coarse_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            app_add_reg   <= 1'b0;
            rf_coarse_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            app_add_reg   <= app_add_next;
            rf_coarse_reg <= rf_coarse_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        app_add_next   = app_add_reg;
        rf_coarse_next = rf_coarse_reg;
        cmd.op         = OP_NONE;
        cmd.kind       = KIND_DONE;
        in_ready       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLR;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.act_add)
                begin
                    if (status.tid_paused || status.add_bad)
                    begin
                        cmd.kind = status.tid_paused ? KIND_ALREADY : KIND_RANGE;
                        if (status.out_free)
                        begin
                            cmd.op     = OP_PUSH;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.op       = OP_ADD_SETUP;
                        app_add_next = 1'b1;
                        state_next   = ST_APP_RD;
                    end
                end
                else if (status.act_remove)
                begin
                    if (!status.tid_paused)
                    begin
                        cmd.kind = KIND_NOT_PAUSED;
                        if (status.out_free)
                        begin
                            cmd.op     = OP_PUSH;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.op     = OP_UL_RD;
                        state_next = ST_UL_A;
                    end
                end
                else if (status.act_advance && status.more_ticks)
                    state_next = ST_TICK;
                else
                    state_next = ST_FINISH;
            end
            ST_APP_RD:
            begin
                cmd.op     = OP_SLOT_RD;
                state_next = ST_APP_WR;
            end
            ST_APP_WR:
            begin
                cmd.op     = OP_APP_WR;
                state_next = ST_APP_LINK;
            end
            ST_APP_LINK:
            begin
                if (!status.tail_nil)
                    cmd.op = OP_APP_LINK;
                state_next = app_add_reg ? ST_ADD_DONE : ST_RF_CHK;
            end
            ST_ADD_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_ADD_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_UL_A:
            begin
                cmd.op     = OP_UL_A;
                state_next = ST_UL_B;
            end
            ST_UL_B:
            begin
                cmd.op     = OP_UL_B;
                state_next = ST_REM_DONE;
            end
            ST_REM_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_REM_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (status.fine_zero && status.mid_zero && status.coarse_ok)
                begin
                    cmd.op         = OP_SEL_COARSE;
                    rf_coarse_next = 1'b1;
                    state_next     = ST_RF_RD;
                end
                else if (status.fine_zero)
                begin
                    cmd.op         = OP_SEL_MID;
                    rf_coarse_next = 1'b0;
                    state_next     = ST_RF_RD;
                end
                else
                begin
                    cmd.op     = OP_SEL_FINE;
                    state_next = ST_EX_RD;
                end
            end
            ST_RF_RD:
            begin
                cmd.op     = OP_SLOT_RD;
                state_next = ST_RF_TAKE;
            end
            ST_RF_TAKE:
            begin
                cmd.op     = OP_TAKE;
                state_next = ST_RF_CHK;
            end
            ST_RF_CHK:
            begin
                if (!status.walk_nil)
                begin
                    cmd.op     = OP_RF_RD;
                    state_next = ST_RF_SET;
                end
                else if (rf_coarse_reg)
                begin
                    cmd.op         = OP_SEL_MID;
                    rf_coarse_next = 1'b0;
                    state_next     = ST_RF_RD;
                end
                else
                begin
                    cmd.op     = OP_SEL_FINE;
                    state_next = ST_EX_RD;
                end
            end
            ST_RF_SET:
            begin
                cmd.op       = OP_RF_SET;
                app_add_next = 1'b0;
                state_next   = ST_APP_RD;
            end
            ST_EX_RD:
            begin
                cmd.op     = OP_SLOT_RD;
                state_next = ST_EX_TAKE;
            end
            ST_EX_TAKE:
            begin
                cmd.op     = OP_TAKE;
                state_next = ST_EX_CHK;
            end
            ST_EX_CHK:
            begin
                if (status.walk_nil)
                begin
                    cmd.op     = OP_TICK_END;
                    state_next = ST_TICK_CHK;
                end
                else if (!status.pend_valid || status.out_free)
                begin
                    cmd.op     = OP_EX;
                    state_next = ST_EX_NEXT;
                end
            end
            ST_EX_NEXT:
            begin
                cmd.op     = OP_EX_NEXT;
                state_next = ST_EX_CHK;
            end
            ST_TICK_CHK:
            begin
                state_next = status.more_ticks ? ST_TICK : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
